FILE: src/cvg_pkg.sv
// Shared types, constants and width helpers for the cell voltage guard.
package cvg_pkg;

	localparam int unsigned NUM_CELLS     = 4;
	localparam int unsigned RAW_W         = 12;
	localparam int unsigned MV_W          = 12;
	localparam int unsigned VLIM_W        = 13;
	localparam int unsigned TEMP_W        = 12;
	localparam int unsigned CFG_W         = 13;
	localparam int unsigned CFG_IDX_W     = 2;
	localparam int unsigned DEFAULT_DEPTH = 8;

	// 3300 / 4095 reduced by their common factor 15
	localparam int unsigned MV_NUM = 220;
	localparam int unsigned MV_DEN = 273;

	localparam int unsigned OVER_MV_RST  = 4200;
	localparam int unsigned UNDER_MV_RST = 3000;
	localparam logic signed [TEMP_W-1:0] TEMP_LIM_RST = 12'sd450;

	typedef enum logic [1:0] {
		FUNC_SAMPLE = 2'd0,
		FUNC_CLEAR  = 2'd1,
		FUNC_INJECT = 2'd2,
		FUNC_STATUS = 2'd3
	} func_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_OVER_MV  = 2'd0,
		CFG_UNDER_MV = 2'd1,
		CFG_TEMP_LIM = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic over;
		logic under;
	} win_t;

	function automatic int unsigned sum_w(input int unsigned depth);
		return $clog2(((2 ** RAW_W) - 1) * depth + 1);
	endfunction

	function automatic int unsigned scaled_w(input int unsigned depth);
		return sum_w(depth) + $clog2(MV_NUM + 1);
	endfunction

	function automatic int unsigned cmp_w(input int unsigned depth);
		int unsigned lim_bits;
		int unsigned x_bits;
		lim_bits = $clog2(((2 ** VLIM_W) - 1) * MV_DEN * depth + 1);
		x_bits   = scaled_w(depth);
		return (lim_bits > x_bits) ? lim_bits : x_bits;
	endfunction

endpackage

FILE: src/cvg_cell.sv
// One cell lane: sample history shift line, running sum and window compare.
module cvg_cell #(
	parameter int unsigned HISTORY_DEPTH = cvg_pkg::DEFAULT_DEPTH
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic                                          shift_en,
	input  logic [cvg_pkg::RAW_W-1:0]                     raw,
	input  logic [cvg_pkg::cmp_w(HISTORY_DEPTH)-1:0]      hi_lim,
	input  logic [cvg_pkg::cmp_w(HISTORY_DEPTH)-1:0]      lo_lim,
	output logic [cvg_pkg::sum_w(HISTORY_DEPTH)-1:0]      sum,
	output cvg_pkg::win_t                                 win
);
	import cvg_pkg::*;

	localparam int unsigned SUM_W = sum_w(HISTORY_DEPTH);
	localparam int unsigned CMP_W = cmp_w(HISTORY_DEPTH);

	logic [RAW_W-1:0] hist_q [HISTORY_DEPTH];
	logic [SUM_W-1:0] sum_q;
	logic [SUM_W-1:0] sum_nxt;
	logic [CMP_W-1:0] scaled;

	assign sum_nxt   = sum_q - SUM_W'(hist_q[HISTORY_DEPTH-1]) + SUM_W'(raw);
	assign scaled    = CMP_W'(sum_nxt) * CMP_W'(MV_NUM);
	assign win.over  = scaled > hi_lim;
	assign win.under = scaled < lo_lim;
	assign sum       = sum_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < HISTORY_DEPTH; i++) begin
				hist_q[i] <= '0;
			end
			sum_q <= '0;
		end else if (shift_en) begin
			hist_q[0] <= raw;
			for (int i = 1; i < HISTORY_DEPTH; i++) begin
				hist_q[i] <= hist_q[i-1];
			end
			sum_q <= sum_nxt;
		end
	end

endmodule

FILE: src/cvg_scale.sv
// Two-stage sum to millivolt conversion by reciprocal multiply and one correction step.
module cvg_scale #(
	parameter int unsigned HISTORY_DEPTH = cvg_pkg::DEFAULT_DEPTH
) (
	input  logic                                     clk,
	input  logic                                     en_s3,
	input  logic                                     en_s4,
	input  logic [cvg_pkg::sum_w(HISTORY_DEPTH)-1:0] sum,
	output logic [cvg_pkg::MV_W-1:0]                 mv
);
	import cvg_pkg::*;

	localparam int unsigned SUM_W = sum_w(HISTORY_DEPTH);
	localparam int unsigned XW    = scaled_w(HISTORY_DEPTH);
	localparam int unsigned PW    = 2 * SUM_W;
	localparam int unsigned NDIV  = MV_DEN * HISTORY_DEPTH;
	localparam longint unsigned RECIP = (longint'(MV_NUM) << SUM_W) / NDIV;

	logic [PW-1:0]   prod;
	logic [XW-1:0]   x_s3;
	logic [MV_W-1:0] q_s3;
	logic [XW-1:0]   qn;
	logic [XW-1:0]   rem;
	logic [MV_W-1:0] q_fix;
	logic [MV_W-1:0] mv_s4;

	assign prod  = PW'(sum) * PW'(RECIP);
	assign qn    = XW'(q_s3) * XW'(NDIV);
	assign rem   = x_s3 - qn;
	assign q_fix = (rem >= XW'(NDIV)) ? q_s3 + MV_W'(1) : q_s3;
	assign mv    = mv_s4;

	always_ff @(posedge clk) begin
		if (en_s3) begin
			x_s3 <= XW'(sum) * XW'(MV_NUM);
			q_s3 <= prod[SUM_W +: MV_W];
		end
		if (en_s4) begin
			mv_s4 <= q_fix;
		end
	end

endmodule

FILE: src/cell_voltage_guard_top.sv
// Top level of the four-cell voltage guard: config, pipeline control and fault latch.
// The block takes one beat per clock while the output is not stalled and returns one
// result beat for each, through an input register, the update of the per-cell history,
// sums and fault latch, and two stages that turn each sum into millivolts. The feedback
// through the running sums and the fault latch sets that rate. Sample beats (func 0)
// shift each cell's reading into a HISTORY_DEPTH-deep moving window; the window starts
// cleared, so early samples read low. On a sample beat, a cell outside its mV window, or
// a temperature above the limit, latches the fault; func 1 clears it only when the last
// voltage check passed, func 2 sets it, func 3 reports only. Limits are written through
// cfg_wr/cfg_idx/cfg_data; the user must write only while the block is idle (not enforced).
module cell_voltage_guard_top #(
	parameter int unsigned HISTORY_DEPTH = cvg_pkg::DEFAULT_DEPTH
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_wr,
	input  logic [cvg_pkg::CFG_IDX_W-1:0]        cfg_idx,
	input  logic [cvg_pkg::CFG_W-1:0]            cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  cvg_pkg::func_t                       func,
	input  logic [cvg_pkg::RAW_W-1:0]            cell0_raw,
	input  logic [cvg_pkg::RAW_W-1:0]            cell1_raw,
	input  logic [cvg_pkg::RAW_W-1:0]            cell2_raw,
	input  logic [cvg_pkg::RAW_W-1:0]            cell3_raw,
	input  logic signed [cvg_pkg::TEMP_W-1:0]    temperature,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [cvg_pkg::MV_W-1:0]             cell0_mv,
	output logic [cvg_pkg::MV_W-1:0]             cell1_mv,
	output logic [cvg_pkg::MV_W-1:0]             cell2_mv,
	output logic [cvg_pkg::MV_W-1:0]             cell3_mv,
	output logic                                 voltage_fault,
	output logic                                 fault_latched,
	output logic                                 output_on
);
	import cvg_pkg::*;

	localparam int unsigned SUM_W  = sum_w(HISTORY_DEPTH);
	localparam int unsigned CMP_W  = cmp_w(HISTORY_DEPTH);
	localparam int unsigned NDIV   = MV_DEN * HISTORY_DEPTH;
	localparam logic [CMP_W-1:0] HI_RST = CMP_W'(OVER_MV_RST * NDIV);
	localparam logic [CMP_W-1:0] LO_RST = CMP_W'(UNDER_MV_RST * NDIV);

	logic [CMP_W-1:0]         hi_lim_q;
	logic [CMP_W-1:0]         lo_lim_q;
	logic signed [TEMP_W-1:0] temp_lim_q;

	logic v1_q, v2_q, v3_q, v4_q;
	logic rdy1, rdy2, rdy3, rdy4;
	logic adv1, adv2, adv3, adv4;

	func_t                    func_s1;
	logic [RAW_W-1:0]         raw_s1 [NUM_CELLS];
	logic signed [TEMP_W-1:0] temp_s1;
	logic [RAW_W-1:0]         raw_in [NUM_CELLS];

	logic [SUM_W-1:0] sum_c [NUM_CELLS];
	win_t             win_c [NUM_CELLS];
	logic [MV_W-1:0]  mv_c  [NUM_CELLS];
	logic             sample_en;
	logic             vfault;
	logic             temp_hot;

	logic latch_q, last_vf_q;
	logic vf_s3, latch_s3, vf_s4, latch_s4;

	assign raw_in[0] = cell0_raw;
	assign raw_in[1] = cell1_raw;
	assign raw_in[2] = cell2_raw;
	assign raw_in[3] = cell3_raw;

	// Config registers; voltage limits are stored pre-scaled by MV_DEN * HISTORY_DEPTH to match the sum times MV_NUM
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hi_lim_q   <= HI_RST;
			lo_lim_q   <= LO_RST;
			temp_lim_q <= TEMP_LIM_RST;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				CFG_OVER_MV:  hi_lim_q   <= CMP_W'(cfg_data) * CMP_W'(NDIV);
				CFG_UNDER_MV: lo_lim_q   <= CMP_W'(cfg_data) * CMP_W'(NDIV);
				CFG_TEMP_LIM: temp_lim_q <= $signed(cfg_data[TEMP_W-1:0]);
				default: begin
				end
			endcase
		end
	end

	assign rdy4 = !v4_q || !out_stall;
	assign rdy3 = !v3_q || rdy4;
	assign rdy2 = !v2_q || rdy3;
	assign rdy1 = !v1_q || rdy2;
	assign adv1 = in_valid && rdy1;
	assign adv2 = v1_q && rdy2;
	assign adv3 = v2_q && rdy3;
	assign adv4 = v3_q && rdy4;
	assign in_stall = !rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
			v4_q <= 1'b0;
		end else begin
			if (rdy1) v1_q <= in_valid;
			if (rdy2) v2_q <= v1_q;
			if (rdy3) v3_q <= v2_q;
			if (rdy4) v4_q <= v3_q;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			func_s1 <= func;
			temp_s1 <= temperature;
			for (int c = 0; c < NUM_CELLS; c++) begin
				raw_s1[c] <= raw_in[c];
			end
		end
	end

	assign sample_en = adv2 && (func_s1 == FUNC_SAMPLE);

	for (genvar c = 0; c < NUM_CELLS; c++) begin : g_cell
		cvg_cell #(
			.HISTORY_DEPTH(HISTORY_DEPTH)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.shift_en(sample_en),
			.raw     (raw_s1[c]),
			.hi_lim  (hi_lim_q),
			.lo_lim  (lo_lim_q),
			.sum     (sum_c[c]),
			.win     (win_c[c])
		);

		cvg_scale #(
			.HISTORY_DEPTH(HISTORY_DEPTH)
		) u_scale (
			.clk  (clk),
			.en_s3(adv3),
			.en_s4(adv4),
			.sum  (sum_c[c]),
			.mv   (mv_c[c])
		);
	end

	always_comb begin
		vfault = 1'b0;
		for (int c = 0; c < NUM_CELLS; c++) begin
			vfault = vfault | win_c[c].over | win_c[c].under;
		end
	end

	assign temp_hot = temp_s1 > temp_lim_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			latch_q   <= 1'b0;
			last_vf_q <= 1'b0;
		end else if (adv2) begin
			unique case (func_s1)
				FUNC_SAMPLE: begin
					last_vf_q <= vfault;
					if (vfault || temp_hot) latch_q <= 1'b1;
				end
				FUNC_CLEAR: begin
					if (!last_vf_q) latch_q <= 1'b0;
				end
				FUNC_INJECT: begin
					latch_q <= 1'b1;
				end
				FUNC_STATUS: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (adv3) begin
			vf_s3    <= last_vf_q;
			latch_s3 <= latch_q;
		end
		if (adv4) begin
			vf_s4    <= vf_s3;
			latch_s4 <= latch_s3;
		end
	end

	assign out_valid     = v4_q;
	assign cell0_mv      = mv_c[0];
	assign cell1_mv      = mv_c[1];
	assign cell2_mv      = mv_c[2];
	assign cell3_mv      = mv_c[3];
	assign voltage_fault = vf_s4;
	assign fault_latched = latch_s4;
	assign output_on     = ~latch_s4;

	a_inject_sets: assert property (@(posedge clk) disable iff (!arst_n)
		(adv2 && func_s1 == FUNC_INJECT) |=> latch_q)
		else $error("fault latch not set after inject beat");

	a_clear_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		(adv2 && func_s1 == FUNC_CLEAR && last_vf_q) |=> (latch_q == $past(latch_q)))
		else $error("fault latch changed by clear beat while voltage fault stands");

	a_sample_fault_sets: assert property (@(posedge clk) disable iff (!arst_n)
		(sample_en && (vfault || temp_hot)) |=> latch_q)
		else $error("fault latch not set by faulty sample beat");

	a_nonsample_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(adv2 && func_s1 != FUNC_SAMPLE) |=> ($stable(sum_c[0]) && $stable(last_vf_q)))
		else $error("cell sum or voltage check changed by non-sample beat");

endmodule

FILE: tb/tb_cell_voltage_guard_top.sv
// Self-checking testbench for the four-cell voltage guard: random traffic, limits, fault latch.
module tb_cell_voltage_guard_top;
	import cvg_pkg::*;

	localparam int HIST_DEPTH     = DEFAULT_DEPTH;
	localparam int NUM_PHASES     = 8;
	localparam int PHASE_ITEMS    = 229;
	localparam int DRAIN_CYCLES   = 10;
	localparam int LONG_HOLD      = 250;
	localparam int WATCHDOG_LIMIT = 5000;

	typedef struct packed {
		func_t                     func;
		logic [3:0][RAW_W-1:0]     raw;
		logic signed [TEMP_W-1:0]  temperature;
	} cmd_t;

	typedef struct packed {
		logic [3:0][MV_W-1:0] mv;
		logic                 vfault;
		logic                 latched;
		logic                 on;
	} report_t;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        cfg_wr = 1'b0;
	logic [CFG_IDX_W-1:0]        cfg_idx = '0;
	logic [CFG_W-1:0]            cfg_data = '0;
	logic                        in_valid = 1'b0;
	logic                        in_stall;
	func_t                       func = FUNC_SAMPLE;
	logic [RAW_W-1:0]            cell0_raw = '0;
	logic [RAW_W-1:0]            cell1_raw = '0;
	logic [RAW_W-1:0]            cell2_raw = '0;
	logic [RAW_W-1:0]            cell3_raw = '0;
	logic signed [TEMP_W-1:0]    temperature = '0;
	logic                        out_valid;
	logic                        out_stall = 1'b0;
	logic [MV_W-1:0]             cell0_mv;
	logic [MV_W-1:0]             cell1_mv;
	logic [MV_W-1:0]             cell2_mv;
	logic [MV_W-1:0]             cell3_mv;
	logic                        voltage_fault;
	logic                        fault_latched;
	logic                        output_on;

	cell_voltage_guard_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr        (cfg_wr),
		.cfg_idx       (cfg_idx),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.func          (func),
		.cell0_raw     (cell0_raw),
		.cell1_raw     (cell1_raw),
		.cell2_raw     (cell2_raw),
		.cell3_raw     (cell3_raw),
		.temperature   (temperature),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.cell0_mv      (cell0_mv),
		.cell1_mv      (cell1_mv),
		.cell2_mv      (cell2_mv),
		.cell3_mv      (cell3_mv),
		.voltage_fault (voltage_fault),
		.fault_latched (fault_latched),
		.output_on     (output_on)
	);

	always #4 clk = ~clk;

	cmd_t    cmd_q[$];
	report_t report_q[$];
	int      n_errors = 0;

	logic [RAW_W-1:0]          cell_hist [4][HIST_DEPTH];
	int unsigned               cell_acc [4];
	int                        next_slot;
	logic                      latch_q;
	logic                      last_vfault;
	logic [VLIM_W-1:0]         lim_over;
	logic [VLIM_W-1:0]         lim_under;
	logic signed [TEMP_W-1:0]  lim_temp;
	int                        base_raw [4];

	function automatic report_t guard_predict(input cmd_t c);
		report_t     r;
		int unsigned hi;
		int unsigned lo;
		int unsigned scaled;
		logic        vf;
		hi = lim_over * 32'd32760;
		lo = lim_under * 32'd32760;
		if (c.func == FUNC_SAMPLE) begin
			vf = 1'b0;
			for (int k = 0; k < 4; k++) begin
				cell_acc[k] = cell_acc[k] - cell_hist[k][next_slot] + c.raw[k];
				cell_hist[k][next_slot] = c.raw[k];
				scaled = cell_acc[k] * 32'd3300;
				if (scaled > hi || scaled < lo)
					vf = 1'b1;
			end
			next_slot = (next_slot == HIST_DEPTH - 1) ? 0 : next_slot + 1;
			last_vfault = vf;
			if (vf)
				latch_q = 1'b1;
			if (c.temperature > lim_temp)
				latch_q = 1'b1;
		end else if (c.func == FUNC_CLEAR) begin
			if (!last_vfault)
				latch_q = 1'b0;
		end else if (c.func == FUNC_INJECT) begin
			latch_q = 1'b1;
		end
		for (int k = 0; k < 4; k++)
			r.mv[k] = 12'((cell_acc[k] * 32'd3300) / 32'd32760);
		r.vfault  = last_vfault;
		r.latched = latch_q;
		r.on      = ~latch_q;
		return r;
	endfunction

	task automatic push_cmd(input func_t f, input int r0, input int r1, input int r2,
			input int r3, input int t);
		cmd_t c;
		c.func        = f;
		c.raw[0]      = 12'(r0);
		c.raw[1]      = 12'(r1);
		c.raw[2]      = 12'(r2);
		c.raw[3]      = 12'(r3);
		c.temperature = 12'(t);
		cmd_q.push_back(c);
	endtask

	task automatic push_random_cmd();
		int    sel;
		int    v [4];
		int    t;
		func_t f;
		sel = $urandom_range(0, 99);
		if (sel < 65)
			f = FUNC_SAMPLE;
		else if (sel < 75)
			f = FUNC_SAMPLE;
		else if (sel < 87)
			f = FUNC_CLEAR;
		else if (sel < 92)
			f = FUNC_INJECT;
		else
			f = FUNC_STATUS;
		for (int k = 0; k < 4; k++) begin
			if (sel < 65) begin
				v[k] = base_raw[k] + int'($urandom_range(0, 40)) - 20;
				if (v[k] < 0)
					v[k] = 0;
				if (v[k] > 4095)
					v[k] = 4095;
			end else begin
				v[k] = $urandom_range(0, 4095);
			end
		end
		sel = $urandom_range(0, 99);
		if (sel < 80)
			t = int'($urandom_range(0, int'(lim_temp) + 400)) - 400;
		else if (sel < 88)
			t = int'(lim_temp);
		else
			t = int'($urandom_range(0, 1650)) - 400;
		push_cmd(f, v[0], v[1], v[2], v[3], t);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] data);
		@(posedge clk);
		cfg_wr   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= data;
		case (idx)
			CFG_OVER_MV:  lim_over = data;
			CFG_UNDER_MV: lim_under = data;
			CFG_TEMP_LIM: lim_temp = data[TEMP_W-1:0];
			default: ;
		endcase
	endtask

	task automatic wait_drained();
		do begin
			@(posedge clk);
			#1;
		end while (cmd_q.size() != 0 || report_q.size() != 0 || in_valid);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// sender: bursts and gaps, predict on every accepted beat
	cmd_t cur_cmd;
	int   gap_left = 0;
	int   burst_left = 0;

	always @(posedge clk) begin : drv
		if (arst_n) begin
			if (in_valid && !in_stall)
				report_q.push_back(guard_predict(cur_cmd));
			if (!in_valid || !in_stall) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (cmd_q.size() != 0) begin
					cur_cmd = cmd_q.pop_front();
					func        <= cur_cmd.func;
					cell0_raw   <= cur_cmd.raw[0];
					cell1_raw   <= cur_cmd.raw[1];
					cell2_raw   <= cur_cmd.raw[2];
					cell3_raw   <= cur_cmd.raw[3];
					temperature <= cur_cmd.temperature;
					in_valid    <= 1'b1;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 200)
							: $urandom_range(0, 40);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver: check beats, stall on a changing pattern, hold off long twice
	int n_reports = 0;
	int hold_left = 0;
	int stall_mode = 0;
	int mode_left = 0;
	int tick = 0;

	always @(posedge clk) begin : mon
		report_t got;
		report_t want;
		logic    nxt;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				got.mv[0]   = cell0_mv;
				got.mv[1]   = cell1_mv;
				got.mv[2]   = cell2_mv;
				got.mv[3]   = cell3_mv;
				got.vfault  = voltage_fault;
				got.latched = fault_latched;
				got.on      = output_on;
				if (report_q.size() == 0) begin
					$error("result beat with nothing expected");
					n_errors++;
				end else begin
					want = report_q.pop_front();
					for (int k = 0; k < 4; k++)
						if (got.mv[k] !== want.mv[k]) begin
							$error("cell%0d_mv: expected %0d, got %0d", k, want.mv[k], got.mv[k]);
							n_errors++;
						end
					if (got.vfault !== want.vfault) begin
						$error("voltage_fault: expected %0b, got %0b", want.vfault, got.vfault);
						n_errors++;
					end
					if (got.latched !== want.latched) begin
						$error("fault_latched: expected %0b, got %0b", want.latched, got.latched);
						n_errors++;
					end
					if (got.on !== want.on) begin
						$error("output_on: expected %0b, got %0b", want.on, got.on);
						n_errors++;
					end
				end
				n_reports++;
				if (n_reports == 300 || n_reports == 1200)
					hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				nxt = 1'b1;
			end else begin
				if (mode_left == 0) begin
					stall_mode = $urandom_range(0, 3);
					mode_left  = $urandom_range(20, 200);
				end else begin
					mode_left--;
				end
				case (stall_mode)
					0: nxt = 1'b0;
					1: nxt = ($urandom_range(0, 9) < 3);
					2: nxt = ($urandom_range(0, 9) < 7);
					default: nxt = (tick % 4 == 3);
				endcase
			end
			tick++;
			out_stall <= nxt;
		end
	end

	int quiet = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr)
				quiet = 0;
			else
				quiet++;
			if (quiet >= WATCHDOG_LIMIT) begin
				$display("** cell_voltage_guard_top: FAILED **");
				$finish;
			end
		end
	end

	initial begin
		int lo_mv;
		int hi_mv;
		int mv;
		int ov;
		int un;
		int tl;
		for (int k = 0; k < 4; k++) begin
			cell_acc[k] = 0;
			for (int s = 0; s < HIST_DEPTH; s++)
				cell_hist[k][s] = '0;
		end
		next_slot   = 0;
		latch_q     = 1'b0;
		last_vfault = 1'b0;
		lim_over    = VLIM_W'(OVER_MV_RST);
		lim_under   = VLIM_W'(UNDER_MV_RST);
		lim_temp    = TEMP_LIM_RST;

		push_cmd(FUNC_SAMPLE, 0, 0, 0, 0, 0);
		push_cmd(FUNC_CLEAR, 0, 0, 0, 0, 0);
		push_cmd(FUNC_STATUS, 4095, 4095, 4095, 4095, 1250);
		for (int i = 0; i < 8; i++)
			push_cmd(FUNC_SAMPLE, 4095, 4095, 4095, 4095, 450);
		push_cmd(FUNC_CLEAR, 0, 0, 0, 0, 0);
		push_cmd(FUNC_SAMPLE, 4095, 4095, 4095, 4095, 451);
		push_cmd(FUNC_CLEAR, 0, 0, 0, 0, 0);
		push_cmd(FUNC_INJECT, 0, 0, 0, 0, 0);
		push_cmd(FUNC_STATUS, 0, 0, 0, 0, 0);
		push_cmd(FUNC_CLEAR, 0, 0, 0, 0, 0);
		push_cmd(FUNC_SAMPLE, 4095, 4095, 4095, 4095, -400);
		push_cmd(FUNC_SAMPLE, 4095, 4095, 4095, 4095, 1250);
		push_cmd(FUNC_SAMPLE, 0, 4095, 12'haaa, 12'h555, 0);
		push_cmd(FUNC_STATUS, 0, 0, 0, 0, 0);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		wait_drained();

		for (int p = 0; p < NUM_PHASES; p++) begin
			case (p)
				0: begin ov = 8191; un = 0;    tl = 1250; end
				1: begin ov = 0;    un = 8191; tl = -400; end
				2: begin ov = 3300; un = 3000; tl = 450;  end
				3: begin ov = 3300; un = 0;    tl = 0;    end
				default: begin
					un = $urandom_range(0, 3300);
					ov = $urandom_range(un, 3500);
					tl = int'($urandom_range(0, 1650)) - 400;
				end
			endcase
			write_reg(CFG_OVER_MV, 13'(ov));
			write_reg(CFG_UNDER_MV, 13'(un));
			write_reg(CFG_TEMP_LIM, {1'($urandom_range(0, 1)), 12'(tl)});
			@(posedge clk);
			cfg_wr <= 1'b0;

			lo_mv = un;
			hi_mv = (ov > 3300) ? 3300 : ov;
			for (int k = 0; k < 4; k++) begin
				if (lo_mv <= hi_mv && $urandom_range(0, 9) < 8) begin
					mv = $urandom_range(lo_mv, hi_mv);
					base_raw[k] = (mv * 4095 + 3299) / 3300;
					if (base_raw[k] > 4095)
						base_raw[k] = 4095;
				end else begin
					base_raw[k] = $urandom_range(0, 4095);
				end
			end
			for (int i = 0; i < PHASE_ITEMS; i++)
				push_random_cmd();
			wait_drained();
		end

		if (report_q.size() != 0) begin
			$error("%0d expected result beats never arrived", report_q.size());
			n_errors++;
		end
		if (n_errors == 0)
			$display("** cell_voltage_guard_top: PASSED **");
		else
			$display("** cell_voltage_guard_top: FAILED **");
		$finish;
	end

endmodule

FILE: cell_voltage_guard_top.f
src/cvg_pkg.sv
src/cvg_cell.sv
src/cvg_scale.sv
src/cell_voltage_guard_top.sv
tb/tb_cell_voltage_guard_top.sv
